// ----- src/vdlc_pkg.sv -----
// Package for the vertex degree / dead-end counter: codes, field widths, shared types.
package vdlc_pkg;

  // Input item selector codes (carried on s_axis_tuser)
  localparam logic FUNC_ADD_EDGE = 1'b0;
  localparam logic FUNC_QUERY    = 1'b1;

  // Fixed field widths of the stream beats and the configuration register
  localparam int unsigned VtxW    = 11;
  localparam int unsigned DegOutW = 16;
  localparam int unsigned CntOutW = 11;
  localparam int unsigned NumVW   = 11;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic REG_NUM_VERTICES = 1'b0;

  // Effect of one degree step on the dead-end tally
  typedef struct packed {
    logic inc;   // vertex reached degree one
    logic dec;   // vertex left degree one
  } tally_t;

endpackage

// ----- src/vertex_degree_leaf_counter_unit.sv -----
// Top level: vertex degree table with running dead-end (degree one) count.
//
//  port group   | dir | beat contents
//  s_axis_*     | in  | tuser: func; tdata: vertex_a[10:0], vertex_b[21:11]
//  m_axis_*     | out | tuser: bad_vertex; tdata: degree[15:0], is_dead_end[16],
//               |     |        dead_end_count[27:17]
//  APB          | cfg | 0x0: num_vertices[10:0]
//
// After reset the degree memory is swept to zero, one entry a cycle, with
// s_axis_tready low. One item at a time through a single-port memory and one
// shared saturating incrementer: an edge reads and updates each end in turn, a
// query reads vertex_a only, and an item with a bad vertex skips the memory. A
// finished result sits in the output register; the next item is taken while it
// waits, and its result is held back until the output register frees up.
module vertex_degree_leaf_counter_unit #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned DEGREE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // vertex_a[10:0], vertex_b[21:11], zero pad
  input  logic [0:0]  s_axis_tuser,   // func[0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // degree[15:0], is_dead_end[16],
                                      // dead_end_count[27:17], zero pad
  output logic [0:0]  m_axis_tuser,   // bad_vertex[0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned VW = vdlc_pkg::VtxW;
  localparam logic [16:0] MaxV = 17'(MAX_VERTICES);
  localparam logic [AW-1:0] LastAddr = AW'(MAX_VERTICES - 1);
  localparam logic [DEGREE_WIDTH-1:0] DegOne = DEGREE_WIDTH'(1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RD_A, ST_UPD_A, ST_RD_B, ST_UPD_B, ST_FIN
  } state_e;

  state_e state_q, state_d;

  // ---------------- configuration ----------------
  logic [vdlc_pkg::NumVW-1:0] num_v_q, num_v_d;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == vdlc_pkg::REG_NUM_VERTICES);
  assign num_v_d = cfg_we ? pwdata[vdlc_pkg::NumVW-1:0] : num_v_q;

  always_comb begin
    prdata = '0;
    if (paddr[2] == vdlc_pkg::REG_NUM_VERTICES) begin
      prdata = 32'(num_v_q);
    end
  end

  // ---------------- input decode ----------------
  logic [VW-1:0] in_a, in_b;
  logic          in_func;
  logic          a_ok, b_ok, in_bad;

  assign in_a    = s_axis_tdata[VW-1:0];
  assign in_b    = s_axis_tdata[2*VW-1:VW];
  assign in_func = s_axis_tuser[0];

  function automatic logic vtx_ok(input logic [VW-1:0] v,
                                  input logic [vdlc_pkg::NumVW-1:0] nv);
    logic [16:0] v17;
    v17 = 17'(v);
    return (v != '0) && (v <= nv) && (v17 <= MaxV);
  endfunction

  function automatic logic [AW-1:0] vtx_idx(input logic [VW-1:0] v);
    logic [16:0] m1;
    m1 = 17'(v) - 17'd1;
    return m1[AW-1:0];
  endfunction

  assign a_ok   = vtx_ok(in_a, num_v_q);
  assign b_ok   = vtx_ok(in_b, num_v_q);
  assign in_bad = (in_func == vdlc_pkg::FUNC_QUERY) ? !a_ok : !(a_ok && b_ok);

  // ---------------- item registers ----------------
  logic [AW-1:0]           idx_a_q, idx_a_d, idx_b_q, idx_b_d, clr_q, clr_d;
  logic                    func_q, func_d, bad_q, bad_d;
  logic [DEGREE_WIDTH-1:0] deg_a_q, deg_a_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    m_valid_q, m_valid_d, m_bad_q, m_bad_d;
  logic [31:0]             m_data_q, m_data_d;

  // ---------------- degree memory ----------------
  logic [DEGREE_WIDTH-1:0] mem [MAX_VERTICES];
  logic [DEGREE_WIDTH-1:0] rdata_q;
  logic [AW-1:0]           mem_addr;
  logic                    mem_we;
  logic [DEGREE_WIDTH-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  // shared incrementer
  logic [DEGREE_WIDTH-1:0] bump_nxt;
  vdlc_pkg::tally_t        bump_tally;

  vdlc_bump #(
    .DEGREE_WIDTH(DEGREE_WIDTH)
  ) u_bump (
    .old_i  (rdata_q),
    .nxt_o  (bump_nxt),
    .tally_o(bump_tally)
  );

  // result formatting
  logic [31:0] deg_ext;
  logic [16:0] cnt_ext;
  logic [31:0] res_data;

  assign deg_ext = 32'(deg_a_q);
  assign cnt_ext = 17'(cnt_q);
  always_comb begin
    res_data = '0;
    if (!bad_q) begin
      res_data[15:0] = deg_ext[vdlc_pkg::DegOutW-1:0];
      res_data[16]   = (deg_a_q == DegOne);
    end
    res_data[27:17] = cnt_ext[vdlc_pkg::CntOutW-1:0];
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_bad_q;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d   = state_q;
    idx_a_d   = idx_a_q;
    idx_b_d   = idx_b_q;
    clr_d     = clr_q;
    func_d    = func_q;
    bad_d     = bad_q;
    deg_a_d   = deg_a_q;
    cnt_d     = cnt_q;
    m_valid_d = m_valid_q;
    m_bad_d   = m_bad_q;
    m_data_d  = m_data_q;
    mem_addr  = idx_a_q;
    mem_we    = 1'b0;
    mem_wdata = bump_nxt;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_addr  = clr_q;
        mem_we    = 1'b1;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          func_d  = in_func;
          bad_d   = in_bad;
          idx_a_d = vtx_idx(in_a);
          idx_b_d = vtx_idx(in_b);
          state_d = in_bad ? ST_FIN : ST_RD_A;
        end
      end
      ST_RD_A: begin
        state_d = ST_UPD_A;
      end
      ST_UPD_A: begin
        if (func_q == vdlc_pkg::FUNC_QUERY) begin
          deg_a_d = rdata_q;
          state_d = ST_FIN;
        end else begin
          mem_we  = 1'b1;
          deg_a_d = bump_nxt;
          cnt_d   = cnt_q + CW'(bump_tally.inc) - CW'(bump_tally.dec);
          state_d = ST_RD_B;
        end
      end
      ST_RD_B: begin
        mem_addr = idx_b_q;
        state_d  = ST_UPD_B;
      end
      ST_UPD_B: begin
        mem_addr = idx_b_q;
        mem_we   = 1'b1;
        cnt_d    = cnt_q + CW'(bump_tally.inc) - CW'(bump_tally.dec);
        // self-loop: the second bump lands on vertex_a too
        if (idx_b_q == idx_a_q) begin
          deg_a_d = bump_nxt;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_bad_d   = bad_q;
          m_data_d  = res_data;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      cnt_q     <= '0;
      num_v_q   <= 11'd1024;
      m_valid_q <= 1'b0;
      func_q    <= vdlc_pkg::FUNC_ADD_EDGE;
      bad_q     <= 1'b0;
      idx_a_q   <= '0;
      idx_b_q   <= '0;
      deg_a_q   <= '0;
      m_bad_q   <= 1'b0;
      m_data_q  <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      cnt_q     <= cnt_d;
      num_v_q   <= num_v_d;
      m_valid_q <= m_valid_d;
      func_q    <= func_d;
      bad_q     <= bad_d;
      idx_a_q   <= idx_a_d;
      idx_b_q   <= idx_b_d;
      deg_a_q   <= deg_a_d;
      m_bad_q   <= m_bad_d;
      m_data_q  <= m_data_d;
    end
  end

endmodule

// ----- src/vdlc_bump.sv -----
// Saturating degree increment with its dead-end tally effect.
module vdlc_bump #(
  parameter int unsigned DEGREE_WIDTH = 16
) (
  input  logic [DEGREE_WIDTH-1:0] old_i,
  output logic [DEGREE_WIDTH-1:0] nxt_o,
  output vdlc_pkg::tally_t        tally_o
);

  localparam logic [DEGREE_WIDTH-1:0] DegMax = '1;
  localparam logic [DEGREE_WIDTH-1:0] DegOne = DEGREE_WIDTH'(1);

  assign nxt_o = (old_i == DegMax) ? old_i : old_i + DegOne;

  always_comb begin
    tally_o.inc = (old_i != DegOne) && (nxt_o == DegOne);
    tally_o.dec = (old_i == DegOne) && (nxt_o != DegOne);
  end

endmodule

// ----- tb/sv/degree_tally_checker.sv -----
// Checker for the degree / dead-end counter: predicts each result beat and compares it.
`timescale 1ns / 100ps
module degree_tally_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // vertex_a[10:0], vertex_b[21:11]
  input  logic [0:0]  s_axis_tuser,   // func[0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // degree[15:0], is_dead_end[16], dead_end_count[27:17]
  input  logic [0:0]  m_axis_tuser,   // bad_vertex[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned fail_cnt_o,
  output int unsigned rsp_cnt_o,
  output int unsigned open_cnt_o
);

  localparam int unsigned VTX_LIMIT = 1024;
  localparam logic [vdlc_pkg::DegOutW-1:0] DEG_SAT = '1;
  localparam logic [2:0] NUM_VERTICES_ADDR = {vdlc_pkg::REG_NUM_VERTICES, 2'b00};

  typedef struct packed {
    logic [vdlc_pkg::DegOutW-1:0] degree;
    logic                         dead_end;
    logic [vdlc_pkg::CntOutW-1:0] leaf_total;
    logic                         bad_vtx;
  } deg_result_t;

  logic [vdlc_pkg::DegOutW-1:0] deg_mem [VTX_LIMIT];
  logic [vdlc_pkg::CntOutW-1:0] leaf_tally;
  logic [vdlc_pkg::NumVW-1:0]   nv_cfg;
  deg_result_t                  result_q [$];
  int unsigned                  fail_cnt = 0;

  assign fail_cnt_o = fail_cnt;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch at result %0d: %s got %0d want %0d",
             $realtime, rsp_cnt_o, what, got, want);
    fail_cnt++;
  endtask

  function automatic logic vertex_ok(input logic [vdlc_pkg::VtxW-1:0] v);
    return (v >= 1) && (v <= nv_cfg) && (v <= VTX_LIMIT);
  endfunction

  // one saturating increment; the tally follows entries that reach or leave degree one
  task automatic degree_step(input logic [vdlc_pkg::VtxW-1:0] v);
    logic [vdlc_pkg::DegOutW-1:0] old_deg;
    logic [vdlc_pkg::DegOutW-1:0] new_deg;
    old_deg = deg_mem[v - 1];
    new_deg = (old_deg == DEG_SAT) ? old_deg : old_deg + 1'b1;
    if (old_deg == 1 && new_deg != 1) leaf_tally--;
    if (old_deg != 1 && new_deg == 1) leaf_tally++;
    deg_mem[v - 1] = new_deg;
  endtask

  task automatic predict_beat(input logic f, input logic [vdlc_pkg::VtxW-1:0] va,
                              input logic [vdlc_pkg::VtxW-1:0] vb);
    deg_result_t r;
    r.bad_vtx = !vertex_ok(va) || (f == vdlc_pkg::FUNC_ADD_EDGE && !vertex_ok(vb));
    if (r.bad_vtx) begin
      r.degree   = '0;
      r.dead_end = 1'b0;
    end else begin
      if (f == vdlc_pkg::FUNC_ADD_EDGE) begin
        degree_step(va);
        degree_step(vb);
      end
      r.degree   = deg_mem[va - 1];
      r.dead_end = (deg_mem[va - 1] == 1);
    end
    r.leaf_total = leaf_tally;
    result_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    deg_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < VTX_LIMIT; i++) deg_mem[i] = '0;
      leaf_tally = '0;
      nv_cfg     = vdlc_pkg::NumVW'(VTX_LIMIT);
      result_q.delete();
      rsp_cnt_o  <= 0;
      open_cnt_o <= 0;
    end else begin
      if (psel && penable && pready && paddr == NUM_VERTICES_ADDR) begin
        if (pwrite) nv_cfg = pwdata[vdlc_pkg::NumVW-1:0];
        else if (prdata != {{(32 - vdlc_pkg::NumVW){1'b0}}, nv_cfg})
          report_mismatch("num_vertices readback", prdata,
                          {{(32 - vdlc_pkg::NumVW){1'b0}}, nv_cfg});
      end
      // results first: a beat accepted at this edge cannot answer an item taken at it
      if (m_axis_tvalid && m_axis_tready) begin
        rsp_cnt_o <= rsp_cnt_o + 1;
        if (result_q.size() == 0) begin
          report_mismatch("result with nothing expected", m_axis_tdata, 0);
        end else begin
          want = result_q.pop_front();
          if (m_axis_tdata[15:0] != want.degree)
            report_mismatch("degree", m_axis_tdata[15:0], want.degree);
          if (m_axis_tdata[16] != want.dead_end)
            report_mismatch("is_dead_end", m_axis_tdata[16], want.dead_end);
          if (m_axis_tdata[27:17] != want.leaf_total)
            report_mismatch("dead_end_count", m_axis_tdata[27:17], want.leaf_total);
          if (m_axis_tuser[0] != want.bad_vtx)
            report_mismatch("bad_vertex", m_axis_tuser[0], want.bad_vtx);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_beat(s_axis_tuser[0], s_axis_tdata[10:0], s_axis_tdata[21:11]);
      open_cnt_o <= result_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_vertex_degree_leaf_counter_unit.sv -----
// Testbench top for the degree / dead-end counter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_vertex_degree_leaf_counter_unit;

  localparam realtime     CLK_HALF       = 6ns;
  localparam int unsigned RST_CYCLES     = 7;
  localparam int unsigned CYCLE_LIMIT    = 400_000;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned LOOP_ITEMS     = 12;
  localparam int unsigned TAIL_CYCLES    = 12;
  localparam int unsigned VTX_LIMIT      = 1024;
  localparam logic [2:0]  NUM_VERTICES_ADDR = {vdlc_pkg::REG_NUM_VERTICES, 2'b00};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // vertex_a[10:0], vertex_b[21:11]
  logic [0:0]  s_axis_tuser;   // func[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // degree[15:0], is_dead_end[16], dead_end_count[27:17]
  logic [0:0]  m_axis_tuser;   // bad_vertex[0]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_cnt;
  int unsigned rsp_cnt;
  int unsigned open_cnt;
  int unsigned items_sent = 0;
  int unsigned cycle_cnt  = 0;
  logic [vdlc_pkg::NumVW-1:0] cur_nv = vdlc_pkg::NumVW'(VTX_LIMIT);
  logic tx_idle_en  = 1'b0;
  logic rx_idle_en  = 1'b0;
  logic rx_hold_req = 1'b0;

  always #(CLK_HALF) clk = ~clk;

  vertex_degree_leaf_counter_unit u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  degree_tally_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_cnt_o    (fail_cnt),
    .rsp_cnt_o     (rsp_cnt),
    .open_cnt_o    (open_cnt)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : rx_side
    int unsigned stall;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 99) < 18) begin
        stall = $urandom_range(1, 12);
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic f, input logic [vdlc_pkg::VtxW-1:0] va,
                           input logic [vdlc_pkg::VtxW-1:0] vb);
    s_axis_tdata  <= {2'b00, vb, va};
    s_axis_tuser  <= f;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (tx_idle_en && $urandom_range(0, 99) < 18) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (rsp_cnt < items_sent) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // mostly valid vertices with a hot low range for repeated hits, some out of range
  function automatic logic [vdlc_pkg::VtxW-1:0] pick_vertex(
      input logic [vdlc_pkg::NumVW-1:0] nv);
    int unsigned lim;
    int unsigned roll;
    lim  = (nv > VTX_LIMIT) ? VTX_LIMIT : nv;
    roll = $urandom_range(0, 99);
    if (lim == 0 || roll < 6) return vdlc_pkg::VtxW'($urandom);
    if (roll < 8) return '0;
    if (roll < 10) return vdlc_pkg::VtxW'(lim + 1);
    if (roll < 13) return vdlc_pkg::VtxW'($urandom_range(VTX_LIMIT + 1, 2047));
    if (roll < 60) return vdlc_pkg::VtxW'($urandom_range(1, (lim < 12) ? lim : 12));
    return vdlc_pkg::VtxW'($urandom_range(1, lim));
  endfunction

  task automatic run_phase(input logic [vdlc_pkg::NumVW-1:0] nv, input int unsigned n,
                           input logic idle_on, input logic with_hold);
    logic f;
    logic [vdlc_pkg::VtxW-1:0] va;
    logic [vdlc_pkg::VtxW-1:0] vb;
    apb_access(1'b1, NUM_VERTICES_ADDR, {{(32 - vdlc_pkg::NumVW){1'b0}}, nv});
    apb_access(1'b0, NUM_VERTICES_ADDR, '0);
    cur_nv     = nv;
    tx_idle_en = idle_on;
    rx_idle_en = idle_on;
    for (int unsigned k = 0; k < n; k++) begin
      if (with_hold && k == 20) rx_hold_req = 1'b1;
      f  = ($urandom_range(0, 99) < 60) ? vdlc_pkg::FUNC_ADD_EDGE : vdlc_pkg::FUNC_QUERY;
      va = pick_vertex(cur_nv);
      vb = (f == vdlc_pkg::FUNC_QUERY) ? vdlc_pkg::VtxW'($urandom) : pick_vertex(cur_nv);
      send_item(f, va, vb);
    end
    wait_drained();
  endtask

  initial begin : stim
    rst_n         <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset vertex count, range edges, self-loop, ignored vertex_b
    send_item(vdlc_pkg::FUNC_QUERY,    11'd1,    11'd0);
    send_item(vdlc_pkg::FUNC_QUERY,    11'd1024, 11'd2047);
    send_item(vdlc_pkg::FUNC_QUERY,    11'd0,    11'd5);
    send_item(vdlc_pkg::FUNC_QUERY,    11'd1025, 11'd1);
    send_item(vdlc_pkg::FUNC_QUERY,    11'd2047, 11'd1);
    send_item(vdlc_pkg::FUNC_ADD_EDGE, 11'd1,    11'd2);
    send_item(vdlc_pkg::FUNC_ADD_EDGE, 11'd2,    11'd3);
    send_item(vdlc_pkg::FUNC_ADD_EDGE, 11'd5,    11'd5);
    send_item(vdlc_pkg::FUNC_QUERY,    11'd5,    11'd0);
    send_item(vdlc_pkg::FUNC_ADD_EDGE, 11'd1,    11'd0);
    send_item(vdlc_pkg::FUNC_ADD_EDGE, 11'd0,    11'd1);
    send_item(vdlc_pkg::FUNC_ADD_EDGE, 11'd1024, 11'd2047);
    send_item(vdlc_pkg::FUNC_ADD_EDGE, 11'd1025, 11'd4);
    send_item(vdlc_pkg::FUNC_ADD_EDGE, 11'd1024, 11'd1);
    send_item(vdlc_pkg::FUNC_QUERY,    11'd1,    11'd2047);
    send_item(vdlc_pkg::FUNC_QUERY,    11'd3,    11'd1024);
    send_item(vdlc_pkg::FUNC_ADD_EDGE, 11'd1,    11'd1);
    // pile self-loops on the top vertex, back to back
    for (int unsigned i = 0; i < LOOP_ITEMS; i++)
      send_item(vdlc_pkg::FUNC_ADD_EDGE, 11'd1024, 11'd1024);
    send_item(vdlc_pkg::FUNC_QUERY, 11'd1024, 11'd0);
    wait_drained();

    run_phase(11'd1024, 200, 1'b1, 1'b1);
    run_phase(11'd8,    150, 1'b1, 1'b0);
    run_phase(11'd1,    100, 1'b1, 1'b0);
    run_phase(11'd0,     60, 1'b1, 1'b0);
    run_phase(11'd2047, 150, 1'b0, 1'b0);
    run_phase(vdlc_pkg::NumVW'($urandom_range(2, 1023)), 150, 1'b1, 1'b0);
    run_phase(11'd1024, 140, 1'b1, 1'b0);
    run_phase(11'd3,    200, 1'b0, 1'b0);

    if (fail_cnt == 0 && open_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/vdlc_pkg.sv
src/vdlc_bump.sv
src/vertex_degree_leaf_counter_unit.sv
tb/sv/degree_tally_checker.sv
tb/sv/tb_vertex_degree_leaf_counter_unit.sv
